/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mcm_pkg.sv */
// Types and constants for the 4x4 column multiply block.
`timescale 1ns / 1ps

package mcm_pkg;

    localparam int LANES  = 4;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 2;
    localparam int PROD_W = 64;
    localparam int PAIR_W = 65;
    localparam int SUM_W  = 66;
    localparam int RND_W  = 67;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MULT = 1'b1;

    localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

    typedef logic [ELEM_W-1:0]        t_elem;
    typedef t_elem [LANES-1:0]        t_vec;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_sum [LANES-1:0]         t_sum_vec;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         index;
        logic signed [ELEM_W-1:0] elem0;
        logic signed [ELEM_W-1:0] elem1;
        logic signed [ELEM_W-1:0] elem2;
        logic signed [ELEM_W-1:0] elem3;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         column_index;
        logic signed [ELEM_W-1:0] out0;
        logic signed [ELEM_W-1:0] out1;
        logic signed [ELEM_W-1:0] out2;
        logic signed [ELEM_W-1:0] out3;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage

/* rtl/mcm_lane.sv */
// One row lane: four products, then a two-level registered adder tree.
`timescale 1ns / 1ps

module mcm_lane #(
    parameter int COLS = 4
) (
    input  logic              i_clk,
    input  mcm_pkg::t_pipe_ctl i_ctl,
    input  mcm_pkg::t_vec     i_row,
    input  mcm_pkg::t_vec     i_col,
    output mcm_pkg::t_sum     o_sum
);

    logic signed [mcm_pkg::PROD_W-1:0] n_prod [mcm_pkg::LANES];
    logic signed [mcm_pkg::PROD_W-1:0] r_prod [mcm_pkg::LANES];
    logic signed [mcm_pkg::PAIR_W-1:0] r_pair [2];
    logic signed [mcm_pkg::SUM_W-1:0]  r_sum;

    for (genvar c = 0; c < mcm_pkg::LANES; c++) begin : g_col
        if (c < COLS) begin : g_used
            assign n_prod[c] = mcm_pkg::PROD_W'($signed(i_row[c]))
                             * mcm_pkg::PROD_W'($signed(i_col[c]));
        end else begin : g_unused
            assign n_prod[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_prod <= n_prod;
        end
        if (i_ctl.en2) begin
            r_pair[0] <= mcm_pkg::PAIR_W'(r_prod[0]) + mcm_pkg::PAIR_W'(r_prod[1]);
            r_pair[1] <= mcm_pkg::PAIR_W'(r_prod[2]) + mcm_pkg::PAIR_W'(r_prod[3]);
        end
        if (i_ctl.en3) begin
            r_sum <= mcm_pkg::SUM_W'(r_pair[0]) + mcm_pkg::SUM_W'(r_pair[1]);
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/mcm_merge.sv */
// Merge stage: round, saturate and collect the lane sums into the output register.
`timescale 1ns / 1ps

module mcm_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [mcm_pkg::IDX_W-1:0]    i_index,
    input  mcm_pkg::t_sum_vec            i_sum,
    output logic                         o_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mcm_pkg::t_out_item           o_out_data
);

    localparam logic [mcm_pkg::RND_W-1:0] HALF =
        (mcm_pkg::RND_W'(1) << FRAC_BITS) >> 1;

    logic signed [mcm_pkg::RND_W-1:0] w_rnd [mcm_pkg::LANES];
    logic signed [mcm_pkg::RND_W-1:0] w_shf [mcm_pkg::LANES];
    logic [mcm_pkg::LANES-1:0]        w_fit;
    mcm_pkg::t_elem                   w_res [mcm_pkg::LANES];

    logic               r_out_valid;
    mcm_pkg::t_out_item r_out_data;
    mcm_pkg::t_out_item n_out_data;

    for (genvar l = 0; l < mcm_pkg::LANES; l++) begin : g_lane
        logic [mcm_pkg::RND_W-mcm_pkg::ELEM_W:0] w_top;
        assign w_rnd[l] = mcm_pkg::RND_W'($signed(i_sum[l])) + $signed(HALF);
        assign w_shf[l] = w_rnd[l] >>> FRAC_BITS;
        assign w_top    = w_shf[l][mcm_pkg::RND_W-1:mcm_pkg::ELEM_W-1];
        assign w_fit[l] = (&w_top) || !(|w_top);
        assign w_res[l] = w_fit[l] ? w_shf[l][mcm_pkg::ELEM_W-1:0]
                        : (w_rnd[l][mcm_pkg::RND_W-1] ? mcm_pkg::Q_MIN : mcm_pkg::Q_MAX);
    end

    always_comb begin
        n_out_data.column_index = i_index;
        n_out_data.out0         = w_res[0];
        n_out_data.out1         = w_res[1];
        n_out_data.out2         = w_res[2];
        n_out_data.out3         = w_res[3];
        n_out_data.saturated    = !(&w_fit);
    end

    assign o_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/matrix_4x4_column_multiply_top.sv */
// A multiply result passes the product, pair-sum, lane-sum and output registers to o_out_valid.
// Throughput: one item per cycle while the output is not stalled; loads take effect for the very next multiply.
// The pipeline has four register stages: products, pair sums, lane sum, round/saturate output.
// Sync active-low reset zeroes the matrix store and all stage valids at once.
// No clearing pass: the block takes items in the first cycle after reset.
`timescale 1ns / 1ps

module matrix_4x4_column_multiply_top #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mcm_pkg::t_out_item o_out_data
);

    localparam int USED  = (DIM < mcm_pkg::LANES) ? DIM : mcm_pkg::LANES;
    localparam int ROW_W = $clog2(USED);

    logic [mcm_pkg::ELEM_W-1:0] r_store [USED][USED];

    logic                        w_xfer;
    logic                        w_load;
    logic                        w_mult;
    logic                        w_mrg_ready;
    mcm_pkg::t_pipe_ctl          w_ctl;
    mcm_pkg::t_vec               w_col;
    mcm_pkg::t_vec               w_row [mcm_pkg::LANES];
    mcm_pkg::t_sum_vec           w_sum;

    logic                        r_v1, r_v2, r_v3;
    logic [mcm_pkg::IDX_W-1:0]   r_idx1, r_idx2, r_idx3;

    assign w_col[0] = i_in_data.elem0;
    assign w_col[1] = i_in_data.elem1;
    assign w_col[2] = i_in_data.elem2;
    assign w_col[3] = i_in_data.elem3;

    // stall chain: a stage moves when it is empty or the one after it moves
    assign w_ctl.en3  = !r_v3 || w_mrg_ready;
    assign w_ctl.en2  = !r_v2 || w_ctl.en3;
    assign w_ctl.en1  = !r_v1 || w_ctl.en2;
    assign o_in_ready = w_ctl.en1;

    assign w_xfer = i_in_valid && o_in_ready;
    assign w_mult = w_xfer && (i_in_data.command == mcm_pkg::CMD_MULT);
    assign w_load = w_xfer && (i_in_data.command == mcm_pkg::CMD_LOAD)
                 && ({1'b0, i_in_data.index} < 3'(USED));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < USED; r++) begin
                for (int c = 0; c < USED; c++) begin
                    r_store[r][c] <= '0;
                end
            end
        end else if (w_load) begin
            for (int c = 0; c < USED; c++) begin
                r_store[i_in_data.index[ROW_W-1:0]][c] <= w_col[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctl.en1) begin
                r_v1 <= w_mult;
            end
            if (w_ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (w_ctl.en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en1) begin
            r_idx1 <= i_in_data.index;
        end
        if (w_ctl.en2) begin
            r_idx2 <= r_idx1;
        end
        if (w_ctl.en3) begin
            r_idx3 <= r_idx2;
        end
    end

    for (genvar r = 0; r < mcm_pkg::LANES; r++) begin : g_lane
        if (r < USED) begin : g_used
            for (genvar c = 0; c < mcm_pkg::LANES; c++) begin : g_elem
                if (c < USED) begin : g_in
                    assign w_row[r][c] = r_store[r][c];
                end else begin : g_out
                    assign w_row[r][c] = '0;
                end
            end
            mcm_lane #(
                .COLS (USED)
            ) u_lane (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_row (w_row[r]),
                .i_col (w_col),
                .o_sum (w_sum[r])
            );
        end else begin : g_unused
            assign w_row[r] = '0;
            assign w_sum[r] = '0;
        end
    end

    mcm_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v3),
        .i_index     (r_idx3),
        .i_sum       (w_sum),
        .o_ready     (w_mrg_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`include "assert_macros.svh"

    `ASSERT_CLK(a_load_no_issue, i_clk, i_rst_n,
        (w_xfer && !w_mult) |=> !r_v1, "load entered pipe")
    `ASSERT_CLK(a_mult_issue, i_clk, i_rst_n,
        w_mult |=> (r_v1 && r_idx1 == $past(i_in_data.index)), "multiply lost at issue")
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n,
        (r_v3 && !w_mrg_ready) |=> (r_v3 && $stable(r_idx3)), "stalled stage changed")
    `ASSERT_CLK(a_sat_clip, i_clk, i_rst_n,
        (o_out_valid && o_out_data.saturated) |->
            (o_out_data.out0 == mcm_pkg::Q_MAX || o_out_data.out0 == mcm_pkg::Q_MIN ||
             o_out_data.out1 == mcm_pkg::Q_MAX || o_out_data.out1 == mcm_pkg::Q_MIN ||
             o_out_data.out2 == mcm_pkg::Q_MAX || o_out_data.out2 == mcm_pkg::Q_MIN ||
             o_out_data.out3 == mcm_pkg::Q_MAX || o_out_data.out3 == mcm_pkg::Q_MIN),
        "saturated without clipped output")
    `ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3 && !o_out_valid), "pipe not empty after reset")

endmodule
